FILE: design/ins_sort_pkg.sv
// Shared types for the insertion sorter cell chain.
package ins_sort_pkg;

  localparam int unsigned ValueW = 32;

  typedef logic signed [ValueW-1:0] value_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;  // place the broadcast value into the chain
    logic pop;     // shift the chain toward cell 0 by one place
  } cell_ctrl_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic   valid;    // cell holds a value
    logic   greater;  // held value is strictly greater than the broadcast value
    value_t value;
  } cell_tap_t;

endpackage : ins_sort_pkg

FILE: design/ins_sort_cell.sv
// One cell of the sorting chain: holds a single value and its valid bit.
module ins_sort_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ins_sort_pkg::cell_ctrl_t ctrl_i,
  input  ins_sort_pkg::value_t    new_value_i,
  input  ins_sort_pkg::cell_tap_t prev_i,   // neighbor toward the smallest value
  input  ins_sort_pkg::cell_tap_t next_i,   // neighbor toward the largest value
  output ins_sort_pkg::cell_tap_t tap_o
);
  import ins_sort_pkg::*;

  logic   valid_q, valid_d;
  value_t value_q, value_d;
  logic   greater;
  logic   take_prev;
  logic   take_new;

  // Stable ordering: only strictly greater values move up
  assign greater = valid_q && (value_q > new_value_i);

  // Greater cells form a suffix, so the lower neighbor shifting means we shift too
  assign take_prev = ctrl_i.insert && prev_i.greater;
  assign take_new  = ctrl_i.insert && !prev_i.greater &&
                     (greater || (!valid_q && prev_i.valid));

  // Next-state selection
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.pop) begin
      valid_d = next_i.valid;
      value_d = next_i.value;
    end else if (take_prev) begin
      valid_d = 1'b1;
      value_d = prev_i.value;
    end else if (take_new) begin
      valid_d = 1'b1;
      value_d = new_value_i;
    end
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign tap_o = '{valid: valid_q, greater: greater, value: value_q};

endmodule : ins_sort_cell

FILE: design/insertion_sorter.sv
// Top level of the insertion sorter: a chain of compare-and-shift cells.
//
//   channel | ports          | payload
//   --------+----------------+-----------------------------------------------
//   in      | s_t*  (slave)  | tdata[31:0] value, tlast end_of_run
//   out     | m_t*  (master) | tdata[31:0] sorted_value, tlast last_out,
//           |                | tuser overflowed
//
// An input value is compared in every cell at once and inserted in place,
// so inputs are taken one per cycle while a run is being collected.
// The first result shows in the cycle after the final input of a run; the chain
// then shifts toward cell 0 one place per output transfer, so N stored values
// take N output transfers, one per cycle while m_tready_i is high. No input is
// taken until the cycle after the final output transfer. Output is shown
// straight from cell 0 and holds while m_tready_i is low. Reset empties the
// chain at once (valid bits only).
module insertion_sorter #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // [31:0] value
  input  logic        s_tlast_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // [31:0] sorted_value
  output logic        m_tlast_o,
  output logic        m_tuser_o    // [0] overflowed
);
  import ins_sort_pkg::*;

  cell_tap_t  taps [DEPTH];
  cell_tap_t  prev_taps [DEPTH];
  cell_tap_t  next_taps [DEPTH];
  cell_ctrl_t ctrl;
  value_t     new_value;
  logic       drain_q, drain_d;
  logic       ovf_q, ovf_d;
  logic       s_xfer, m_xfer, full;

  assign new_value = value_t'(s_tdata_i);
  assign full      = taps[DEPTH-1].valid;
  assign s_xfer    = s_tvalid_i && s_tready_o;
  assign m_xfer    = m_tvalid_o && m_tready_i;

  assign ctrl.insert = s_xfer && !full;
  assign ctrl.pop    = m_xfer;

  // Neighbor wiring; the chain ends act as an always-valid, never-greater
  // floor and an always-empty ceiling
  always_comb begin
    for (int i = 0; i < int'(DEPTH); i++) begin
      prev_taps[i] = (i == 0) ? cell_tap_t'{valid: 1'b1, greater: 1'b0, value: '0}
                              : taps[(i == 0) ? 0 : i-1];
      next_taps[i] = (i == int'(DEPTH) - 1) ? cell_tap_t'{valid: 1'b0, greater: 1'b0,
                                                           value: '0}
                                            : taps[(i == int'(DEPTH) - 1) ? i : i+1];
    end
  end

  // Cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ins_sort_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_value_i(new_value),
      .prev_i     (prev_taps[g]),
      .next_i     (next_taps[g]),
      .tap_o      (taps[g])
    );
  end

  // Run control: collect, then drain until the final transfer
  always_comb begin
    drain_d = drain_q;
    ovf_d   = ovf_q;
    if (s_xfer && full) begin
      ovf_d = 1'b1;
    end
    if (s_xfer && s_tlast_i) begin
      drain_d = 1'b1;
    end
    if (m_xfer && m_tlast_o) begin
      drain_d = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      drain_q <= drain_d;
      ovf_q   <= ovf_d;
    end
  end

  // Ports
  assign s_tready_o = !drain_q;
  assign m_tvalid_o = drain_q && taps[0].valid;
  assign m_tdata_o  = 32'(taps[0].value);
  assign m_tlast_o  = !taps[1].valid;
  assign m_tuser_o  = ovf_q;

endmodule : insertion_sorter

FILE: design/ins_sort_chk.sv
// Port-level checker for the insertion sorter, bound to the top level.
module ins_sort_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_o,
  input logic        s_tlast_i,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [31:0] m_tdata_o,
  input logic        m_tlast_o,
  input logic        m_tuser_o
);

  // Collecting and draining never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_tready_o && m_tvalid_o))
    else $error("input taken while results pending");

  // A final input starts the drain in the next cycle
  a_drain_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && s_tlast_i) |=> m_tvalid_o)
    else $error("no result after final input");

  // The final result transfer returns the block to collecting
  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tready_i && m_tlast_o) |=> (s_tready_o && !m_tvalid_o))
    else $error("block did not return to collecting");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> (m_tvalid_o && $stable(m_tdata_o) &&
                                      $stable(m_tlast_o) && $stable(m_tuser_o)))
    else $error("stalled result changed");

endmodule : ins_sort_chk

bind insertion_sorter ins_sort_chk u_ins_sort_chk (.*);
